### design/clr_pkg.sv
// shared types, constants and the divider step for the color levels remap block
`default_nettype none

package clr_pkg;

    // component and pipeline geometry
    localparam int COMP_BITS     = 8;
    localparam int NUM_CH        = 3;
    localparam int QUO_BITS      = 2 * COMP_BITS;
    localparam int SUM_BITS      = QUO_BITS + 2;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STAGES    = QUO_BITS / DIV_STEP_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COMP_BITS;
    localparam int MASK_BITS     = NUM_CH;

    localparam logic [COMP_BITS-1:0] COMP_MAX   = {COMP_BITS{1'b1}};
    localparam logic [MASK_BITS-1:0] MASK_RESET = {MASK_BITS{1'b1}};

    typedef logic [COMP_BITS-1:0] comp_t;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_INPUT_LOW    = 3'd0,
        CFG_INPUT_HIGH   = 3'd1,
        CFG_OUTPUT_LOW   = 3'd2,
        CFG_OUTPUT_HIGH  = 3'd3,
        CFG_CHANNEL_MASK = 3'd4
    } cfg_index_t;

    // one lane of the divider: partial remainder and shifting dividend/quotient
    typedef struct packed {
        comp_t               rem;
        logic [QUO_BITS-1:0] work;
    } div_lane_t;

    typedef div_lane_t [NUM_CH-1:0] div_lanes_t;

    // per-item data that rides along with the divider lanes
    typedef struct packed {
        comp_t [NUM_CH-1:0]   comp;
        comp_t                alpha;
        logic  [NUM_CH-1:0]   remap;
        logic  [NUM_CH-1:0]   neg;
        logic                 flat;
    } pix_side_t;

    // one restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic div_lane_t div_step(div_lane_t x, comp_t dq);
        logic [COMP_BITS:0] r;
        div_lane_t          y;
        r      = {x.rem, x.work[QUO_BITS-1]};
        y.work = {x.work[QUO_BITS-2:0], 1'b0};
        if (r >= {1'b0, dq}) begin
            r         = r - {1'b0, dq};
            y.work[0] = 1'b1;
        end
        y.rem = r[COMP_BITS-1:0];
        return y;
    endfunction

endpackage

`default_nettype wire

### design/clr_div_stage.sv
// one registered stage of the pipelined divider, all color lanes side by side
`default_nettype none

module clr_div_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              valid_in,
    input  wire clr_pkg::comp_t    divisor,
    input  wire clr_pkg::div_lanes_t lanes_in,
    input  wire clr_pkg::pix_side_t  side_in,
    output logic                   valid_out,
    output clr_pkg::div_lanes_t    lanes_out,
    output clr_pkg::pix_side_t     side_out
);
    import clr_pkg::*;

    logic       valid_reg;
    div_lanes_t lanes_reg;
    div_lanes_t lanes_next;
    pix_side_t  side_reg;

    // four quotient bits per lane (DIV_STEP_BITS)
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            lanes_next[k] = lanes_in[k];
            for (int s = 0; s < DIV_STEP_BITS; s++) begin
                lanes_next[k] = div_step(lanes_next[k], divisor);
            end
        end
    end

    // stage valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en && valid_in) begin
            lanes_reg <= lanes_next;
            side_reg  <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign lanes_out = lanes_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

### design/color_levels_remap_unit.sv
// top level of the color levels remap block: config registers and remap pipeline
//
// Linear levels adjustment of one RGBA pixel per item. Each color channel
// selected by the channel mask maps to
//   output_low + floor((c - input_low) * (output_high - output_low)
//                      / (input_high - input_low)), clamped to 0..255.
// Unselected channels and alpha pass unchanged. With input_low equal to
// input_high every component passes and m_flat_range is set.
// Input channel s_*, result channel m_*, both valid/ready. Configuration is a
// plain write port (cfg_wr_en, cfg_index, cfg_data); writes to indexes beyond
// the channel mask are dropped. Write it only while no item is in flight.
// Pipeline: seven register stages (input subtract, multiply, four divider
// stages of four quotient bits each, floor/offset/clamp), in that order.
// Throughput: one item per cycle while m_ready holds. The 16-bit quotient
// comes from the pipelined divider, four bits per stage.
// Stall: each stage holds its item while the next is full and stalled; empty
// stages keep filling, so s_ready drops only once all seven stages are full.
// Reset: aresetn low empties the pipeline and restores the register defaults
// (full input and output range, all three channels enabled).
`default_nettype none

module color_levels_remap_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [clr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [clr_pkg::CFG_DATA_BITS-1:0] cfg_data,
    // pixel input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_red_in,
    input  wire logic [7:0]                    s_green_in,
    input  wire logic [7:0]                    s_blue_in,
    input  wire logic [7:0]                    s_alpha_in,
    // pixel output
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_red_out,
    output logic [7:0]                         m_green_out,
    output logic [7:0]                         m_blue_out,
    output logic [7:0]                         m_alpha_out,
    output logic                               m_flat_range
);
    import clr_pkg::*;

    localparam int NSTAGES = DIV_STAGES + 3;
    localparam int OUT_ST  = NSTAGES - 1;

    // configuration registers
    comp_t                in_lo_reg, in_hi_reg, out_lo_reg, out_hi_reg;
    logic [MASK_BITS-1:0] mask_reg;

    // values derived from the configuration
    logic signed [COMP_BITS:0] p_reg;
    logic signed [COMP_BITS:0] p_next;
    logic signed [COMP_BITS:0] q_next;
    logic                      flat_next;
    comp_t                     qmag_reg;
    logic                      qneg_reg;
    logic                      flat_reg;

    // stage handshake
    logic [NSTAGES-1:0] stage_valid;
    logic [NSTAGES-1:0] stage_en;

    // stage 1: input offset
    logic                              s1_valid_reg;
    logic signed [COMP_BITS:0]         s1_d_reg [NUM_CH];
    pix_side_t                         s1_side_reg;
    pix_side_t                         s1_side_next;
    comp_t [NUM_CH-1:0]                s_comp;

    // stage 2: product magnitude and quotient sign
    logic                              s2_valid_reg;
    div_lanes_t                        s2_lanes_reg;
    div_lanes_t                        s2_lanes_next;
    pix_side_t                         s2_side_reg;
    pix_side_t                         s2_side_next;
    logic signed [2*COMP_BITS+1:0]     prod [NUM_CH];
    logic [2*COMP_BITS+1:0]            prod_mag [NUM_CH];

    // divider stages
    logic                              div_valid [DIV_STAGES+1];
    div_lanes_t                        div_lanes [DIV_STAGES+1];
    pix_side_t                         div_side  [DIV_STAGES+1];

    // output stage
    logic                              out_valid_reg;
    comp_t [NUM_CH-1:0]                out_comp_reg;
    comp_t [NUM_CH-1:0]                out_comp_next;
    comp_t                             out_alpha_reg;
    logic                              out_flat_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_lo_reg  <= '0;
            in_hi_reg  <= COMP_MAX;
            out_lo_reg <= '0;
            out_hi_reg <= COMP_MAX;
            mask_reg   <= MASK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_INPUT_LOW:    in_lo_reg  <= cfg_data[COMP_BITS-1:0];
                CFG_INPUT_HIGH:   in_hi_reg  <= cfg_data[COMP_BITS-1:0];
                CFG_OUTPUT_LOW:   out_lo_reg <= cfg_data[COMP_BITS-1:0];
                CFG_OUTPUT_HIGH:  out_hi_reg <= cfg_data[COMP_BITS-1:0];
                CFG_CHANNEL_MASK: mask_reg   <= cfg_data[MASK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // output span and input span with its sign split off
    always_comb begin
        p_next    = $signed({1'b0, out_hi_reg}) - $signed({1'b0, out_lo_reg});
        q_next    = $signed({1'b0, in_hi_reg}) - $signed({1'b0, in_lo_reg});
        flat_next = (q_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg    <= $signed({1'b0, COMP_MAX});
            qmag_reg <= COMP_MAX;
            qneg_reg <= 1'b0;
            flat_reg <= 1'b0;
        end else begin
            p_reg    <= p_next;
            qmag_reg <= q_next[COMP_BITS] ? comp_t'(-q_next) : q_next[COMP_BITS-1:0];
            qneg_reg <= q_next[COMP_BITS];
            flat_reg <= flat_next;
        end
    end

    // stage enables: a stage moves when empty or when the one after it moves
    always_comb begin
        stage_valid = {out_valid_reg, div_valid[DIV_STAGES], div_valid[DIV_STAGES-1],
                       div_valid[DIV_STAGES-2], div_valid[DIV_STAGES-3],
                       s2_valid_reg, s1_valid_reg};
        stage_en[OUT_ST] = !stage_valid[OUT_ST] || m_ready;
        for (int i = OUT_ST - 1; i >= 0; i--) begin
            stage_en[i] = !stage_valid[i] || stage_en[i+1];
        end
    end

    assign s_ready = stage_en[0];

    // stage 1: subtract input low, decide which channels remap
    always_comb begin
        s_comp = {s_blue_in, s_green_in, s_red_in};
        s1_side_next.comp  = s_comp;
        s1_side_next.alpha = s_alpha_in;
        s1_side_next.flat  = flat_next;
        s1_side_next.neg   = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            s1_side_next.remap[k] = !flat_next && mask_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (stage_en[0]) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0] && s_valid) begin
            for (int k = 0; k < NUM_CH; k++) begin
                s1_d_reg[k] <= $signed({1'b0, s_comp[k]}) - $signed({1'b0, in_lo_reg});
            end
            s1_side_reg <= s1_side_next;
        end
    end

    // stage 2: multiply by the output span, split into sign and magnitude
    always_comb begin
        s2_side_next = s1_side_reg;
        for (int k = 0; k < NUM_CH; k++) begin
            prod[k]              = SUM_BITS'(s1_d_reg[k]) * SUM_BITS'(p_reg);
            prod_mag[k]          = prod[k][2*COMP_BITS+1] ? -prod[k] : prod[k];
            s2_lanes_next[k].rem  = '0;
            s2_lanes_next[k].work = prod_mag[k][QUO_BITS-1:0];
            s2_side_next.neg[k]   = prod[k][2*COMP_BITS+1] ^ qneg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (stage_en[1]) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1] && s1_valid_reg) begin
            s2_lanes_reg <= s2_lanes_next;
            s2_side_reg  <= s2_side_next;
        end
    end

    // divider pipeline, magnitude of the product over magnitude of the input span
    assign div_valid[0] = s2_valid_reg;
    assign div_lanes[0] = s2_lanes_reg;
    assign div_side[0]  = s2_side_reg;

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        clr_div_stage u_div_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (stage_en[j+2]),
            .valid_in  (div_valid[j]),
            .divisor   (qmag_reg),
            .lanes_in  (div_lanes[j]),
            .side_in   (div_side[j]),
            .valid_out (div_valid[j+1]),
            .lanes_out (div_lanes[j+1]),
            .side_out  (div_side[j+1])
        );
    end

    // floor toward minus infinity, add output low, clamp, select pass-through
    always_comb begin
        logic signed [SUM_BITS-1:0] quo;
        logic signed [SUM_BITS-1:0] delta;
        logic signed [SUM_BITS-1:0] sum;
        logic                       nz;
        comp_t                      clamped;
        quo     = '0;
        delta   = '0;
        sum     = '0;
        nz      = 1'b0;
        clamped = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            quo   = $signed({2'b00, div_lanes[DIV_STAGES][k].work});
            nz    = |div_lanes[DIV_STAGES][k].rem;
            delta = div_side[DIV_STAGES].neg[k]
                    ? -quo - $signed({{(SUM_BITS-1){1'b0}}, nz}) : quo;
            sum   = $signed({{(SUM_BITS-COMP_BITS){1'b0}}, out_lo_reg}) + delta;
            if (sum[SUM_BITS-1]) begin
                clamped = '0;
            end else if (|sum[SUM_BITS-2:COMP_BITS]) begin
                clamped = COMP_MAX;
            end else begin
                clamped = sum[COMP_BITS-1:0];
            end
            out_comp_next[k] = div_side[DIV_STAGES].remap[k]
                               ? clamped : div_side[DIV_STAGES].comp[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stage_en[OUT_ST]) begin
            out_valid_reg <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[OUT_ST] && div_valid[DIV_STAGES]) begin
            out_comp_reg  <= out_comp_next;
            out_alpha_reg <= div_side[DIV_STAGES].alpha;
            out_flat_reg  <= div_side[DIV_STAGES].flat;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_red_out    = out_comp_reg[0];
    assign m_green_out  = out_comp_reg[1];
    assign m_blue_out   = out_comp_reg[2];
    assign m_alpha_out  = out_alpha_reg;
    assign m_flat_range = out_flat_reg;

    // derived span registers agree on a flat range
    a_flat_span: assert property (@(posedge aclk) disable iff (!aresetn)
        flat_reg == (qmag_reg == '0))
        else $error("flat flag disagrees with input span");

    // an empty first stage always takes an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_ready)
        else $error("input stalled with an empty first stage");

    // divider remainder stays below the divisor on every lane of a non-flat item
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid[DIV_STAGES] && !div_side[DIV_STAGES].flat |->
            div_lanes[DIV_STAGES][0].rem < qmag_reg &&
            div_lanes[DIV_STAGES][1].rem < qmag_reg &&
            div_lanes[DIV_STAGES][2].rem < qmag_reg)
        else $error("divider remainder out of range");

    // a flat range result never comes from a remapped channel
    a_flat_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid[DIV_STAGES] && div_side[DIV_STAGES].flat |->
            div_side[DIV_STAGES].remap == '0)
        else $error("remap selected on a flat range");

endmodule

`default_nettype wire

### tb/levels_remap_checker.sv
// checker for the color levels remap block: tracks the config, predicts each pixel, compares
module levels_remap_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [clr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [clr_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [7:0]                        s_red_in,
    input  logic [7:0]                        s_green_in,
    input  logic [7:0]                        s_blue_in,
    input  logic [7:0]                        s_alpha_in,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [7:0]                        m_red_out,
    input  logic [7:0]                        m_green_out,
    input  logic [7:0]                        m_blue_out,
    input  logic [7:0]                        m_alpha_out,
    input  logic                              m_flat_range,
    output int                                error_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import clr_pkg::*;

    localparam longint LEVEL_TOP = (longint'(1) << COMP_BITS) - 1;

    typedef struct packed {
        comp_t red;
        comp_t green;
        comp_t blue;
        comp_t alpha;
        logic  flat;
    } levels_pixel_t;

    // shadow copy of the level registers
    comp_t                lvl_in_lo;
    comp_t                lvl_in_hi;
    comp_t                lvl_out_lo;
    comp_t                lvl_out_hi;
    logic [MASK_BITS-1:0] lvl_mask;

    levels_pixel_t expected_pixels[$];

    // floor of num / den, den nonzero
    function automatic longint floor_quot(longint num, longint den);
        longint q;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // exact linear remap of one component, saturated to the component range
    function automatic comp_t remap_level(comp_t c);
        longint cv, il, ih, ol, oh, v;
        cv = longint'(c);
        il = longint'(lvl_in_lo);
        ih = longint'(lvl_in_hi);
        ol = longint'(lvl_out_lo);
        oh = longint'(lvl_out_hi);
        v  = ol + floor_quot((cv - il) * (oh - ol), ih - il);
        if (v < 0) begin
            v = 0;
        end
        if (v > LEVEL_TOP) begin
            v = LEVEL_TOP;
        end
        return comp_t'(v);
    endfunction

    // whole pixel: flat input range passes everything and raises the flag
    function automatic levels_pixel_t predict_pixel(comp_t r, comp_t g, comp_t b, comp_t a);
        levels_pixel_t p;
        p.flat  = (lvl_in_lo == lvl_in_hi);
        p.red   = (!p.flat && lvl_mask[0]) ? remap_level(r) : r;
        p.green = (!p.flat && lvl_mask[1]) ? remap_level(g) : g;
        p.blue  = (!p.flat && lvl_mask[2]) ? remap_level(b) : b;
        p.alpha = a;
        return p;
    endfunction

    task automatic check_field(string field, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
            error_count++;
        end
    endtask

    // watch config writes, accepted pixels and accepted results
    always @(posedge aclk) begin
        levels_pixel_t want;
        if (!aresetn) begin
            lvl_in_lo  = '0;
            lvl_in_hi  = COMP_MAX;
            lvl_out_lo = '0;
            lvl_out_hi = COMP_MAX;
            lvl_mask   = MASK_RESET;
            expected_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_INPUT_LOW:    lvl_in_lo  = cfg_data;
                    CFG_INPUT_HIGH:   lvl_in_hi  = cfg_data;
                    CFG_OUTPUT_LOW:   lvl_out_lo = cfg_data;
                    CFG_OUTPUT_HIGH:  lvl_out_hi = cfg_data;
                    CFG_CHANNEL_MASK: lvl_mask   = cfg_data[MASK_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_pixels.push_back(predict_pixel(s_red_in, s_green_in, s_blue_in,
                                                        s_alpha_in));
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result item with no pixel outstanding");
                    error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red_out", int'(want.red), int'(m_red_out));
                    check_field("green_out", int'(want.green), int'(m_green_out));
                    check_field("blue_out", int'(want.blue), int'(m_blue_out));
                    check_field("alpha_out", int'(want.alpha), int'(m_alpha_out));
                    check_field("flat_range", int'(want.flat), int'(m_flat_range));
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

### tb/tb_top.sv
// testbench top for the color levels remap block: clock, reset, stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clr_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int HOLD_CYCLES     = 60;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 200;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic [7:0]               s_red_in   = '0;
    logic [7:0]               s_green_in = '0;
    logic [7:0]               s_blue_in  = '0;
    logic [7:0]               s_alpha_in = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [7:0]               m_red_out;
    logic [7:0]               m_green_out;
    logic [7:0]               m_blue_out;
    logic [7:0]               m_alpha_out;
    logic                     m_flat_range;

    int    error_count;
    int    pending;
    int    burst_left = 0;
    bit    hold_req   = 1'b0;
    bit    hold_done  = 1'b0;
    comp_t cur_in_lo  = '0;
    comp_t cur_in_hi  = COMP_MAX;

    color_levels_remap_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .s_alpha_in   (s_alpha_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_alpha_out  (m_alpha_out),
        .m_flat_range (m_flat_range)
    );

    levels_remap_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .s_alpha_in   (s_alpha_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_alpha_out  (m_alpha_out),
        .m_flat_range (m_flat_range),
        .error_count  (error_count),
        .pending      (pending)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // offer one pixel, with a random gap at the start of each burst
    task automatic send_pixel(comp_t r, comp_t g, comp_t b, comp_t a);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge aclk);
                s_valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid    = 1'b1;
        s_red_in   = r;
        s_green_in = g;
        s_blue_in  = b;
        s_alpha_in = a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, comp_t data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // stop offering and let every pixel in flight come out
    task automatic drain_pipe();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // new level setting, written only with the block empty
    task automatic load_levels(comp_t in_lo, comp_t in_hi, comp_t out_lo, comp_t out_hi,
                               comp_t mask_data);
        drain_pipe();
        write_reg(CFG_INPUT_LOW, in_lo);
        write_reg(CFG_INPUT_HIGH, in_hi);
        write_reg(CFG_OUTPUT_LOW, out_lo);
        write_reg(CFG_OUTPUT_HIGH, out_hi);
        write_reg(CFG_CHANNEL_MASK, mask_data);
        // writes to unused indexes must be dropped
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_IDX_BITS'($urandom_range(CFG_CHANNEL_MASK + 1,
                                                   (1 << CFG_IDX_BITS) - 1)),
                      comp_t'($urandom_range(0, 255)));
        end
        cur_in_lo = in_lo;
        cur_in_hi = in_hi;
    endtask

    // component value, biased toward the range ends
    function automatic comp_t pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COMP_MAX;
            2: return cur_in_lo;
            3: return cur_in_hi;
            4: return cur_in_lo + 8'd1;
            5: return cur_in_hi - 8'd1;
            default: return comp_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic comp_t pick_reg();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return COMP_MAX;
            default: return comp_t'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: ready pattern changes per stretch, one long hold-off on request
    initial begin
        ready_mode_t mode;
        int          span;
        int          tick;
        tick = 0;
        forever begin
            mode = ready_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge aclk);
                tick++;
                if (hold_req && !hold_done) begin
                    m_ready = 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge aclk);
                    hold_done = 1'b1;
                end else begin
                    case (mode)
                        READY_ALWAYS:   m_ready = 1'b1;
                        READY_COIN:     m_ready = 1'($urandom_range(0, 1));
                        READY_SPARSE:   m_ready = ($urandom_range(0, 3) == 0);
                        READY_PERIODIC: m_ready = ((tick % 5) < 3);
                        default:        m_ready = 1'b1;
                    endcase
                end
            end
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_top: errors");
        $finish;
    end

    // stimulus and verdict
    initial begin
        comp_t lo;
        comp_t hi;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults: full range, all channels
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd128, 8'd254, 8'h55);

        // decreasing output mapping
        load_levels(8'd0, 8'd255, 8'd255, 8'd0, 8'd7);
        send_pixel(8'd0, 8'd255, 8'd128, 8'haa);
        send_pixel(8'd17, 8'd200, 8'd3, 8'd1);

        // decreasing input mapping, green passes
        load_levels(8'd255, 8'd0, 8'd0, 8'd255, 8'd5);
        send_pixel(8'd0, 8'd255, 8'd77, 8'd128);
        send_pixel(8'd255, 8'd12, 8'd1, 8'd254);

        // flat input range: everything passes and the flag is raised
        load_levels(8'd100, 8'd100, 8'd10, 8'd20, 8'd7);
        send_pixel(8'd100, 8'd0, 8'd255, 8'd7);
        send_pixel(8'd5, 8'd100, 8'd200, 8'd0);

        // narrow input window: saturation at both ends
        load_levels(8'd50, 8'd60, 8'd0, 8'd255, 8'd7);
        send_pixel(8'd0, 8'd55, 8'd255, 8'd3);
        send_pixel(8'd49, 8'd50, 8'd60, 8'd250);
        send_pixel(8'd61, 8'd59, 8'd51, 8'd9);

        // one-step input range with a decreasing output, steep slope
        load_levels(8'd254, 8'd255, 8'd255, 8'd0, 8'd3);
        send_pixel(8'd254, 8'd255, 8'd0, 8'd64);
        send_pixel(8'd253, 8'd0, 8'd255, 8'd192);

        // single output level, mask data with extra high bits, unused index write
        load_levels(8'd0, 8'd255, 8'd128, 8'd128, 8'hfe);
        write_reg(CFG_IDX_BITS'(CFG_CHANNEL_MASK + 1), 8'd0);
        send_pixel(8'd0, 8'd255, 8'd64, 8'd32);
        send_pixel(8'd200, 8'd1, 8'd255, 8'd16);

        // no channel selected
        load_levels(8'd10, 8'd200, 8'd30, 8'd220, 8'd0);
        send_pixel(8'd10, 8'd200, 8'd255, 8'd128);

        // random settings, random pixels
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            lo = pick_reg();
            hi = ($urandom_range(0, 7) == 0) ? lo : pick_reg();
            load_levels(lo, hi, pick_reg(), pick_reg(), comp_t'($urandom_range(0, 255)));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 0 && n == 40) begin
                    hold_req = 1'b1;
                end
                send_pixel(pick_level(), pick_level(), pick_level(),
                           comp_t'($urandom_range(0, 255)));
            end
        end

        drain_pipe();
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
